// ===== sv/spi_msc_pkg.sv =====
`timescale 1ns / 1ps
// shared types and constants of the spi master/slave controller
// no dependencies

package spi_msc_pkg;

    localparam int MAX_FRAME_BITS = 16;
    localparam int WORD_W         = MAX_FRAME_BITS;
    localparam int TOP_W          = $clog2(MAX_FRAME_BITS);
    localparam int COUNT_W        = TOP_W + 1;
    localparam int TICK_W         = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int CFG_DATA_W     = 16;

    localparam logic [TOP_W-1:0]  MIN_FRAME_TOP = TOP_W'(4 - 1);
    localparam logic [TOP_W-1:0]  MAX_FRAME_TOP = TOP_W'(MAX_FRAME_BITS - 1);
    localparam logic [TOP_W-1:0]  RESET_FRAME_TOP = TOP_W'(7);
    localparam logic [TICK_W-1:0] RESET_HALF_PERIOD = TICK_W'(1);

    localparam logic [CFG_INDEX_W-1:0] CFG_SLAVE_MODE     = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_POLARITY = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_TX_DISABLE     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_FRAME_BITS     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_HALF_PERIOD    = 3'd4;

    typedef enum logic [1:0] {
        ACT_TICK   = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_ENABLE = 2'd3
    } action_t;

    typedef struct packed {
        action_t             action;
        logic [WORD_W-1:0]   tx_word;
        logic                enable_value;
        logic                select_pin;
        logic                clock_pin;
        logic                data_in_pin;
    } cmd_t;

    typedef struct packed {
        logic                clock_out;
        logic                select_out;
        logic                data_out;
        logic [WORD_W-1:0]   rx_word;
        logic                rx_word_valid;
        logic                write_accepted;
        logic                busy_res;
        logic                tx_empty;
        logic                tx_not_full;
        logic                rx_not_empty;
        logic                rx_full;
        logic                frame_received;
    } rsp_t;

    typedef struct packed {
        logic                slave_mode;
        logic                clock_polarity;
        logic                tx_output_disable;
        logic [TOP_W-1:0]    frame_bits_minus_one;
        logic [TICK_W-1:0]   half_period_ticks;
    } cfg_t;

endpackage

// ===== sv/spi_master_slave_controller_unit.sv =====
`timescale 1ns / 1ps
// top level of the spi master/slave controller: command and result registers
// depends on spi_msc_pkg, spi_msc_cfg, spi_msc_core
//
// usage
// cmd channel: one transfer per item (timer tick with sampled pins, transmit
//   write, receive read or enable change), taken when cmd_valid is high and
//   cmd_stall is low
// rsp channel: exactly one result per command, in order, taken when
//   rsp_valid is high and rsp_stall is low
// cfg channel: register index and data, taken when cfg_valid and cfg_ready
//   are high; cfg_ready is always high, unknown indexes are ignored
// result path: the command register holds the command, then the result register
//   holds its result until the result transfer
// throughput: one command per cycle while rsp_stall is low, set by the single
//   state-update pass between the command register and the result register
// reset: all controller state, status flags, pins and configuration registers
//   return to their reset values, both channels empty
// receiver stall: the result register holds; one more command is held in
//   the command register, then cmd_stall rises until the result is taken

module spi_master_slave_controller_unit (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cmd_valid,
    output logic                                 cmd_stall,
    input  spi_msc_pkg::cmd_t                    cmd,
    output logic                                 rsp_valid,
    input  logic                                 rsp_stall,
    output spi_msc_pkg::rsp_t                    rsp,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [spi_msc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spi_msc_pkg::CFG_DATA_W-1:0]   cfg_data
);
    import spi_msc_pkg::*;

    cfg_t  cfg;
    cmd_t  cmd_reg;
    logic  cmd_valid_reg;
    rsp_t  rsp_reg;
    rsp_t  rsp_next;
    logic  rsp_valid_reg;
    logic  advance;
    logic  fire;

    assign cfg_ready = 1'b1;
    assign advance   = !rsp_valid_reg || !rsp_stall;
    assign cmd_stall = cmd_valid_reg && !advance;
    assign fire      = cmd_valid_reg && advance;

    spi_msc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    spi_msc_core u_core (
        .clk    (clk),
        .rst_n  (rst_n),
        .fire   (fire),
        .cmd    (cmd_reg),
        .cfg    (cfg),
        .result (rsp_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_valid_reg <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (!cmd_stall)
            begin
                cmd_valid_reg <= cmd_valid;
            end
            if (advance)
            begin
                rsp_valid_reg <= cmd_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (!cmd_stall && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
        if (fire)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== sv/spi_msc_cfg.sv =====
`timescale 1ns / 1ps
// configuration register file of the spi master/slave controller
// depends on spi_msc_pkg

module spi_msc_cfg (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [spi_msc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spi_msc_pkg::CFG_DATA_W-1:0]   cfg_data,
    output spi_msc_pkg::cfg_t                    cfg
);
    import spi_msc_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.slave_mode           <= 1'b0;
            cfg_reg.clock_polarity       <= 1'b0;
            cfg_reg.tx_output_disable    <= 1'b0;
            cfg_reg.frame_bits_minus_one <= RESET_FRAME_TOP;
            cfg_reg.half_period_ticks    <= RESET_HALF_PERIOD;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SLAVE_MODE:     cfg_reg.slave_mode <= cfg_data[0];
                CFG_CLOCK_POLARITY: cfg_reg.clock_polarity <= cfg_data[0];
                CFG_TX_DISABLE:     cfg_reg.tx_output_disable <= cfg_data[0];
                CFG_FRAME_BITS:     cfg_reg.frame_bits_minus_one <= cfg_data[TOP_W-1:0];
                CFG_HALF_PERIOD:    cfg_reg.half_period_ticks <= cfg_data[TICK_W-1:0];
                default:            cfg_reg <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== sv/spi_msc_core.sv =====
`timescale 1ns / 1ps
// controller state and single-pass next-state logic for one transfer
// depends on spi_msc_pkg

module spi_msc_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                fire,
    input  spi_msc_pkg::cmd_t   cmd,
    input  spi_msc_pkg::cfg_t   cfg,
    output spi_msc_pkg::rsp_t   result
);
    import spi_msc_pkg::*;

    logic                enabled_reg, enabled_next;
    logic                working_reg, working_next;
    logic                clock_level_reg, clock_level_next;
    logic [TICK_W-1:0]   tick_count_reg, tick_count_next;
    logic [COUNT_W-1:0]  tx_count_reg, tx_count_next;
    logic [COUNT_W-1:0]  rx_count_reg, rx_count_next;
    logic [WORD_W-1:0]   tx_shift_reg, tx_shift_next;
    logic [WORD_W-1:0]   rx_shift_reg, rx_shift_next;
    logic                tfe_reg, tfe_next;
    logic                tnf_reg, tnf_next;
    logic                rne_reg, rne_next;
    logic                rff_reg, rff_next;
    logic                bsy_reg, bsy_next;
    logic                pin_clk_reg, pin_clk_next;
    logic                pin_sel_reg, pin_sel_next;
    logic                pin_dat_reg, pin_dat_next;

    logic [TOP_W-1:0]    top;
    logic [COUNT_W-1:0]  frame_len;
    logic [WORD_W:0]     mask_wide;
    logic [WORD_W-1:0]   frame_mask;
    logic                pol;
    logic [WORD_W-1:0]   rx_word;
    logic                rx_valid;
    logic                accepted;
    logic                got;
    logic                lead;
    logic                shift_act;
    logic                sample_act;

    always_comb
    begin
        top = (cfg.frame_bits_minus_one < MIN_FRAME_TOP) ? MIN_FRAME_TOP
                                                         : cfg.frame_bits_minus_one;
        if (top > MAX_FRAME_TOP)
        begin
            top = MAX_FRAME_TOP;
        end
        frame_len  = COUNT_W'(top) + COUNT_W'(1);
        mask_wide  = ((WORD_W+1)'(1) << frame_len) - (WORD_W+1)'(1);
        frame_mask = mask_wide[WORD_W-1:0];
    end

    assign pol = cfg.clock_polarity;

    always_comb
    begin
        enabled_next     = enabled_reg;
        working_next     = working_reg;
        clock_level_next = clock_level_reg;
        tick_count_next  = tick_count_reg;
        tx_count_next    = tx_count_reg;
        rx_count_next    = rx_count_reg;
        tx_shift_next    = tx_shift_reg;
        rx_shift_next    = rx_shift_reg;
        tfe_next         = tfe_reg;
        tnf_next         = tnf_reg;
        rne_next         = rne_reg;
        rff_next         = rff_reg;
        bsy_next         = bsy_reg;
        pin_clk_next     = pin_clk_reg;
        pin_sel_next     = pin_sel_reg;
        pin_dat_next     = pin_dat_reg;
        rx_word          = '0;
        rx_valid         = 1'b0;
        accepted         = 1'b0;
        got              = 1'b0;
        lead             = 1'b0;
        shift_act        = 1'b0;
        sample_act       = 1'b0;

        unique case (cmd.action)
            ACT_TICK:
            begin
                if (working_reg || enabled_reg)
                begin
                    if (!working_reg)
                    begin
                        bsy_next     = 1'b0;
                        working_next = 1'b1;
                    end
                    if (cfg.slave_mode)
                    begin
                        if (cmd.select_pin)
                        begin
                            // standby
                            clock_level_next = pol;
                            tx_count_next    = '0;
                            rx_count_next    = '0;
                            bsy_next         = 1'b0;
                            if (!enabled_next)
                            begin
                                working_next = 1'b0;
                            end
                        end
                        else
                        begin
                            bsy_next = 1'b1;
                            if (clock_level_reg && !cmd.clock_pin)
                            begin
                                shift_act        = pol;
                                sample_act       = !pol;
                                clock_level_next = 1'b0;
                            end
                            else if (!clock_level_reg && cmd.clock_pin)
                            begin
                                shift_act        = !pol;
                                sample_act       = pol;
                                clock_level_next = 1'b1;
                            end
                            if (shift_act && !cfg.tx_output_disable && !tfe_reg)
                            begin
                                pin_dat_next  = tx_shift_reg[top];
                                tx_shift_next = {tx_shift_reg[WORD_W-2:0], 1'b0};
                                tx_count_next = tx_count_reg + COUNT_W'(1);
                                if (tx_count_next == frame_len)
                                begin
                                    tx_count_next = '0;
                                    tfe_next      = 1'b1;
                                    tnf_next      = 1'b1;
                                    if (!enabled_reg)
                                    begin
                                        clock_level_next = pol;
                                        tx_count_next    = '0;
                                        rx_count_next    = '0;
                                        bsy_next         = 1'b0;
                                        working_next     = 1'b0;
                                    end
                                end
                            end
                            if (sample_act && !rff_reg)
                            begin
                                rx_shift_next = {rx_shift_reg[WORD_W-2:0], cmd.data_in_pin};
                                rx_count_next = rx_count_reg + COUNT_W'(1);
                                if (rx_count_next == frame_len)
                                begin
                                    rx_count_next = '0;
                                    rx_shift_next = rx_shift_next & frame_mask;
                                    rff_next      = 1'b1;
                                    rne_next      = 1'b1;
                                    got           = 1'b1;
                                end
                            end
                        end
                    end
                    else if (tfe_reg)
                    begin
                        // master standby
                        clock_level_next = pol;
                        tx_count_next    = '0;
                        rx_count_next    = '0;
                        bsy_next         = 1'b0;
                        if (!enabled_reg)
                        begin
                            working_next = 1'b0;
                        end
                        pin_clk_next = pol;
                        pin_sel_next = 1'b1;
                    end
                    else
                    begin
                        bsy_next        = 1'b1;
                        pin_sel_next    = 1'b0;
                        tick_count_next = tick_count_reg + TICK_W'(1);
                        if (tick_count_next == cfg.half_period_ticks)
                        begin
                            lead             = (clock_level_reg == pol);
                            tick_count_next  = '0;
                            clock_level_next = !clock_level_reg;
                            pin_clk_next     = clock_level_next;
                            if (lead)
                            begin
                                pin_dat_next  = tx_shift_reg[top];
                                tx_shift_next = {tx_shift_reg[WORD_W-2:0], 1'b0};
                                tx_count_next = tx_count_reg + COUNT_W'(1);
                            end
                            else
                            begin
                                if (!rff_reg)
                                begin
                                    rx_shift_next = {rx_shift_reg[WORD_W-2:0],
                                                     cmd.data_in_pin};
                                    rx_count_next = rx_count_reg + COUNT_W'(1);
                                    if (rx_count_next == frame_len)
                                    begin
                                        rx_count_next = '0;
                                        rx_shift_next = rx_shift_next & frame_mask;
                                        rff_next      = 1'b1;
                                        rne_next      = 1'b1;
                                        got           = 1'b1;
                                    end
                                end
                                if (tx_count_reg == frame_len)
                                begin
                                    tx_count_next = '0;
                                    tfe_next      = 1'b1;
                                    tnf_next      = 1'b1;
                                    if (!enabled_reg)
                                    begin
                                        clock_level_next = pol;
                                        rx_count_next    = '0;
                                        bsy_next         = 1'b0;
                                        working_next     = 1'b0;
                                        pin_clk_next     = pol;
                                        pin_sel_next     = 1'b1;
                                    end
                                end
                            end
                        end
                    end
                end
            end
            ACT_WRITE:
            begin
                if (tnf_reg)
                begin
                    tx_shift_next = cmd.tx_word;
                    tnf_next      = 1'b0;
                    tfe_next      = 1'b0;
                    accepted      = 1'b1;
                end
            end
            ACT_READ:
            begin
                if (rne_reg)
                begin
                    rx_word  = rx_shift_reg;
                    rx_valid = 1'b1;
                    rne_next = 1'b0;
                    rff_next = 1'b0;
                end
            end
            ACT_ENABLE:
            begin
                enabled_next = cmd.enable_value;
            end
        endcase

        result.clock_out      = pin_clk_next;
        result.select_out     = pin_sel_next;
        result.data_out       = pin_dat_next;
        result.rx_word        = rx_word;
        result.rx_word_valid  = rx_valid;
        result.write_accepted = accepted;
        result.busy_res       = bsy_next;
        result.tx_empty       = tfe_next;
        result.tx_not_full    = tnf_next;
        result.rx_not_empty   = rne_next;
        result.rx_full        = rff_next;
        result.frame_received = got;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            working_reg     <= 1'b0;
            clock_level_reg <= 1'b0;
            tick_count_reg  <= '0;
            tx_count_reg    <= '0;
            rx_count_reg    <= '0;
            tx_shift_reg    <= '0;
            rx_shift_reg    <= '0;
            tfe_reg         <= 1'b1;
            tnf_reg         <= 1'b1;
            rne_reg         <= 1'b0;
            rff_reg         <= 1'b0;
            bsy_reg         <= 1'b0;
            pin_clk_reg     <= 1'b0;
            pin_sel_reg     <= 1'b1;
            pin_dat_reg     <= 1'b0;
        end
        else if (fire)
        begin
            enabled_reg     <= enabled_next;
            working_reg     <= working_next;
            clock_level_reg <= clock_level_next;
            tick_count_reg  <= tick_count_next;
            tx_count_reg    <= tx_count_next;
            rx_count_reg    <= rx_count_next;
            tx_shift_reg    <= tx_shift_next;
            rx_shift_reg    <= rx_shift_next;
            tfe_reg         <= tfe_next;
            tnf_reg         <= tnf_next;
            rne_reg         <= rne_next;
            rff_reg         <= rff_next;
            bsy_reg         <= bsy_next;
            pin_clk_reg     <= pin_clk_next;
            pin_sel_reg     <= pin_sel_next;
            pin_dat_reg     <= pin_dat_next;
        end
    end

endmodule

// ===== sv/spi_msc_checker.sv =====
`timescale 1ns / 1ps
// port-level checks of the spi master/slave controller and their binding
// depends on spi_msc_pkg and spi_master_slave_controller_unit

module spi_msc_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                rsp_valid,
    input  logic                rsp_stall,
    input  spi_msc_pkg::rsp_t   rsp
);
    import spi_msc_pkg::*;

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed");

    // a successful read empties the receive buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.rx_word_valid |-> !rsp.rx_not_empty && !rsp.rx_full)
        else $error("receive buffer not emptied by read");

    // no word without a successful read
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.rx_word_valid |-> rsp.rx_word == '0)
        else $error("received word without read");

    // an accepted write fills the transmit buffer
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.write_accepted |-> !rsp.tx_empty && !rsp.tx_not_full)
        else $error("transmit buffer not filled by write");

    // a completed frame leaves the receive buffer full
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.frame_received |-> rsp.rx_full && rsp.rx_not_empty)
        else $error("frame end without full receive buffer");

endmodule

bind spi_master_slave_controller_unit spi_msc_checker u_spi_msc_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);
